// ----- rtl/a64li_pkg.sv -----
// ----------------------------------------------------------------------------
// a64li_pkg
// Types and helpers shared by the AArch64 logical immediate encoder.
// ----------------------------------------------------------------------------
package a64li_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned SIZE_W  = 7;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               word_is_32;
  } a64li_in_t;

  typedef struct packed {
    logic               encodable;
    logic               n_bit;
    logic [FIELD_W-1:0] imms_field;
    logic [FIELD_W-1:0] immr_field;
  } a64li_res_t;

  // Bit position of a one-hot word; zero when no bit is set.
  function automatic logic [POS_W-1:0] onehot_pos(input logic [VALUE_W-1:0] x);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (x[i]) begin
        pos = pos | POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- rtl/a64li_in_if.sv -----
// ----------------------------------------------------------------------------
// a64li_in_if
// Input channel of the encoder: a candidate value and its operand width.
// ----------------------------------------------------------------------------
interface a64li_in_if;
  import a64li_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               word_is_32;

  modport source (output valid, output value, output word_is_32, input ready);
  modport sink   (input valid, input value, input word_is_32, output ready);

endinterface

// ----- rtl/a64li_out_if.sv -----
// ----------------------------------------------------------------------------
// a64li_out_if
// Result channel of the encoder: the encodable flag and the N, imms, immr fields.
// ----------------------------------------------------------------------------
interface a64li_out_if;
  import a64li_pkg::*;

  logic               valid;
  logic               ready;
  logic               encodable;
  logic               n_bit;
  logic [FIELD_W-1:0] imms_field;
  logic [FIELD_W-1:0] immr_field;

  modport source (output valid, output encodable, output n_bit, output imms_field,
                  output immr_field, input ready);
  modport sink   (input valid, input encodable, input n_bit, input imms_field,
                  input immr_field, output ready);

endinterface

// ----- rtl/a64li_core.sv -----
// ----------------------------------------------------------------------------
// a64li_core
// Combinational bitmask immediate analysis of one registered input word.
// ----------------------------------------------------------------------------
module a64li_core
  import a64li_pkg::*;
(
  input  a64li_in_t  in_data,
  output a64li_res_t res
);

  logic               inv;
  logic [VALUE_W-1:0] v_inv;
  logic [VALUE_W-1:0] v;
  logic [VALUE_W-1:0] a;
  logic [VALUE_W-1:0] sum_a;
  logic [VALUE_W-1:0] b;
  logic [VALUE_W-1:0] rest;
  logic [VALUE_W-1:0] c;
  logic [VALUE_W-1:0] unit;
  logic [POS_W-1:0]   pa;
  logic [POS_W-1:0]   pb;
  logic [POS_W-1:0]   pc;
  logic               a_nz;
  logic               b_nz;
  logic               c_nz;
  logic [SIZE_W-1:0]  d;
  logic [SIZE_W-1:0]  d_m1;
  logic [SIZE_W-1:0]  pb_ext;
  logic [SIZE_W-1:0]  run;
  logic [SIZE_W-1:0]  s;
  logic [SIZE_W-1:0]  s_m1;
  logic [SIZE_W-1:0]  r_full;
  logic [7:0]         size_code;
  logic               ok;

  always_comb begin
    inv   = in_data.value[0];
    v_inv = in_data.value ^ {VALUE_W{inv}};
    v     = in_data.word_is_32 ? {v_inv[31:0], v_inv[31:0]} : v_inv;

    a     = v & (~v + 64'd1);
    sum_a = v + a;
    b     = sum_a & (~sum_a + 64'd1);
    rest  = sum_a - b;
    c     = rest & (~rest + 64'd1);
    unit  = b - a;

    pa   = onehot_pos(a);
    pb   = onehot_pos(b);
    pc   = onehot_pos(c);
    a_nz = |a;
    b_nz = |b;
    c_nz = |c;

    d      = c_nz ? {1'b0, pc - pa} : 7'd64;
    d_m1   = d - 7'd1;
    pb_ext = b_nz ? {1'b0, pb} : 7'd64;
    run    = pb_ext - {1'b0, pa};
    s      = inv ? (d - run) : run;
    s_m1   = s - 7'd1;
    r_full = inv ? (7'd0 - pb_ext) : (7'd0 - {1'b0, pa});

    size_code = 8'd128 - {d, 1'b0};

    case (d)
      7'd2: begin
        ok = (unit[63:2] == '0) && (v == {32{unit[1:0]}});
      end
      7'd4: begin
        ok = (unit[63:4] == '0) && (v == {16{unit[3:0]}});
      end
      7'd8: begin
        ok = (unit[63:8] == '0) && (v == {8{unit[7:0]}});
      end
      7'd16: begin
        ok = (unit[63:16] == '0) && (v == {4{unit[15:0]}});
      end
      7'd32: begin
        ok = (unit[63:32] == '0) && (v == {2{unit[31:0]}});
      end
      7'd64: begin
        ok = (v == unit);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    ok = ok && a_nz;

    res.encodable  = ok;
    res.n_bit      = ok && !c_nz;
    res.imms_field = ok ? (size_code[FIELD_W-1:0] | s_m1[FIELD_W-1:0]) : '0;
    res.immr_field = ok ? (r_full[FIELD_W-1:0] & d_m1[FIELD_W-1:0]) : '0;
  end

endmodule

// ----- rtl/arm64_logical_immediate_encoder.sv -----
// ----------------------------------------------------------------------------
// arm64_logical_immediate_encoder
// Decides whether a value is an AArch64 logical immediate and encodes it.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload
//   in_word   sink       value[63:0], word_is_32
//   out_word  source     encodable, n_bit, imms_field[5:0], immr_field[5:0]
//
// One word is taken every cycle while the input register is empty or advancing; the
// word waits in the input register, and its result is captured in the result register
// when that register is empty or being read, and is offered from there.
// The rate is set by the single pass of the analysis logic between the two.
// A stalled result holds its register while the input register takes one
// further word. Reset clears both valid flags.
module arm64_logical_immediate_encoder
  import a64li_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  a64li_in_if.sink    in_word,
  a64li_out_if.source out_word
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  a64li_in_t  s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  a64li_res_t out_data_r;
  a64li_res_t res;
  logic       s1_adv;
  logic       in_take;

  a64li_core u_core (
    .in_data (s1_data_r),
    .res     (res)
  );

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_word.ready);
  assign in_take = in_word.valid && in_word.ready;

  assign in_word.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r.value      <= in_word.value;
      s1_data_r.word_is_32 <= in_word.word_is_32;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.encodable  = out_data_r.encodable;
  assign out_word.n_bit      = out_data_r.n_bit;
  assign out_word.imms_field = out_data_r.imms_field;
  assign out_word.immr_field = out_data_r.immr_field;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.encodable |->
      !out_data_r.n_bit && (out_data_r.imms_field == '0) && (out_data_r.immr_field == '0))
    else $error("rejected word carries non-zero fields");

  a_n_implies_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.n_bit |-> out_data_r.encodable)
    else $error("N bit set on a rejected word");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted word lost from the input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_take)
    else $error("input register overwritten while held");
`endif

endmodule
